/* hdl/omw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// omw_pkg
// Shared types and constants for the one-wire bus master timing block.
// ----------------------------------------------------------------------------
package omw_pkg;

    localparam int TIMER_BITS_DEF = 10;

    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 10;
    localparam int BYTE_BITS      = 8;
    localparam int BIT_IDX_BITS   = 3;

    // Reset values of the timing registers, in ticks
    localparam logic [CFG_DATA_BITS-1:0] RESET_LOW_DEF     = 10'd500;
    localparam logic [CFG_DATA_BITS-1:0] PRESENCE_WAIT_DEF = 10'd70;
    localparam logic [CFG_DATA_BITS-1:0] RESET_TAIL_DEF    = 10'd420;
    localparam logic [CFG_DATA_BITS-1:0] SLOT_SHORT_DEF    = 10'd10;
    localparam logic [CFG_DATA_BITS-1:0] SLOT_LONG_DEF     = 10'd70;
    localparam logic [CFG_DATA_BITS-1:0] READ_LOW_DEF      = 10'd7;
    localparam logic [CFG_DATA_BITS-1:0] READ_SAMPLE_DEF   = 10'd10;
    localparam logic [CFG_DATA_BITS-1:0] READ_TAIL_DEF     = 10'd60;

    localparam logic [BIT_IDX_BITS-1:0] LAST_BIT = 3'd7;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_SLOT_SHORT    = 3'd3,
        REG_SLOT_LONG     = 3'd4,
        REG_READ_LOW      = 3'd5,
        REG_READ_SAMPLE   = 3'd6,
        REG_READ_TAIL     = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_REL   = 4'd5,
        PH_RD_LOW   = 4'd6,
        PH_RD_WAIT  = 4'd7,
        PH_RD_TAIL  = 4'd8
    } t_phase;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] reset_low_time;
        logic [CFG_DATA_BITS-1:0] presence_wait_time;
        logic [CFG_DATA_BITS-1:0] reset_tail_time;
        logic [CFG_DATA_BITS-1:0] slot_short_time;
        logic [CFG_DATA_BITS-1:0] slot_long_time;
        logic [CFG_DATA_BITS-1:0] read_low_time;
        logic [CFG_DATA_BITS-1:0] read_sample_time;
        logic [CFG_DATA_BITS-1:0] read_tail_time;
    } t_timing;

    typedef struct packed {
        logic                 drive_low;
        logic                 busy_res;
        logic                 done_res;
        logic                 presence;
        logic [BYTE_BITS-1:0] read_data;
        logic                 rejected;
    } t_result;

endpackage
`default_nettype wire

/* hdl/omw_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// omw channel interfaces
// Valid/ready channels for commands, results and timing register writes.
// ----------------------------------------------------------------------------
interface omw_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [omw_pkg::BYTE_BITS-1:0] write_byte;
    logic                          bus_level;

    modport source (output valid, output opcode, output write_byte, output bus_level,
                    input ready);
    modport sink   (input valid, input opcode, input write_byte, input bus_level,
                    output ready);
endinterface

interface omw_out_if;
    logic                          valid;
    logic                          ready;
    logic                          drive_low;
    logic                          busy_res;
    logic                          done_res;
    logic                          presence;
    logic [omw_pkg::BYTE_BITS-1:0] read_data;
    logic                          rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_data, input rejected, output ready);
endinterface

interface omw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [omw_pkg::CFG_IDX_BITS-1:0]  index;
    logic [omw_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/omw_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// omw_cfg
// Timing register file, loaded with defaults at reset.
// ----------------------------------------------------------------------------
module omw_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr_en,
    input  wire logic [omw_pkg::CFG_IDX_BITS-1:0]  i_wr_idx,
    input  wire logic [omw_pkg::CFG_DATA_BITS-1:0] i_wr_data,
    output omw_pkg::t_timing                       o_timing
);

    omw_pkg::t_timing r_timing;
    omw_pkg::t_timing n_timing;

    always_comb begin
        n_timing = r_timing;
        if (i_wr_en) begin
            unique case (omw_pkg::t_reg_idx'(i_wr_idx))
                omw_pkg::REG_RESET_LOW:     n_timing.reset_low_time     = i_wr_data;
                omw_pkg::REG_PRESENCE_WAIT: n_timing.presence_wait_time = i_wr_data;
                omw_pkg::REG_RESET_TAIL:    n_timing.reset_tail_time    = i_wr_data;
                omw_pkg::REG_SLOT_SHORT:    n_timing.slot_short_time    = i_wr_data;
                omw_pkg::REG_SLOT_LONG:     n_timing.slot_long_time     = i_wr_data;
                omw_pkg::REG_READ_LOW:      n_timing.read_low_time      = i_wr_data;
                omw_pkg::REG_READ_SAMPLE:   n_timing.read_sample_time   = i_wr_data;
                omw_pkg::REG_READ_TAIL:     n_timing.read_tail_time     = i_wr_data;
                default:                    n_timing = r_timing;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.reset_low_time     <= omw_pkg::RESET_LOW_DEF;
            r_timing.presence_wait_time <= omw_pkg::PRESENCE_WAIT_DEF;
            r_timing.reset_tail_time    <= omw_pkg::RESET_TAIL_DEF;
            r_timing.slot_short_time    <= omw_pkg::SLOT_SHORT_DEF;
            r_timing.slot_long_time     <= omw_pkg::SLOT_LONG_DEF;
            r_timing.read_low_time      <= omw_pkg::READ_LOW_DEF;
            r_timing.read_sample_time   <= omw_pkg::READ_SAMPLE_DEF;
            r_timing.read_tail_time     <= omw_pkg::READ_TAIL_DEF;
        end else begin
            r_timing <= n_timing;
        end
    end

    assign o_timing = r_timing;

endmodule
`default_nettype wire

/* hdl/omw_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// omw_seq
// Phase sequencer: one timer step or command decision per accepted item.
// ----------------------------------------------------------------------------
module omw_seq #(
    parameter int TIMER_BITS = omw_pkg::TIMER_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [omw_pkg::BYTE_BITS-1:0] i_write_byte,
    input  wire logic                          i_bus_level,
    input  wire omw_pkg::t_timing              i_timing,
    output omw_pkg::t_result                   o_result
);

    omw_pkg::t_phase                      r_phase,   n_phase;
    logic [TIMER_BITS-1:0]                r_timer,   n_timer;
    logic [omw_pkg::BIT_IDX_BITS-1:0]     r_bit_idx, n_bit_idx;
    logic [omw_pkg::BYTE_BITS-1:0]        r_shift,   n_shift;
    logic                                 r_drive,   n_drive;
    logic                                 r_pres,    n_pres;
    logic [omw_pkg::BYTE_BITS-1:0]        r_rdata,   n_rdata;
    logic                                 done;
    logic                                 rej;
    logic                                 busy;

    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        n_drive   = r_drive;
        n_pres    = r_pres;
        n_rdata   = r_rdata;
        done      = 1'b0;
        rej       = 1'b0;
        busy      = (r_phase != omw_pkg::PH_IDLE);

        if (omw_pkg::t_opcode'(i_opcode) != omw_pkg::OP_TICK) begin
            if (busy) begin
                rej = 1'b1;
            end else begin
                n_bit_idx = '0;
                n_drive   = 1'b1;
                unique case (omw_pkg::t_opcode'(i_opcode))
                    omw_pkg::OP_RESET: begin
                        n_phase = omw_pkg::PH_RST_LOW;
                        n_timer = TIMER_BITS'(i_timing.reset_low_time);
                    end
                    omw_pkg::OP_WRITE: begin
                        n_phase = omw_pkg::PH_WR_LOW;
                        n_shift = i_write_byte;
                        n_timer = i_write_byte[0] ? TIMER_BITS'(i_timing.slot_short_time)
                                                  : TIMER_BITS'(i_timing.slot_long_time);
                    end
                    default: begin
                        n_phase = omw_pkg::PH_RD_LOW;
                        n_shift = '0;
                        n_timer = TIMER_BITS'(i_timing.read_low_time);
                    end
                endcase
            end
        end else if (busy) begin
            if (r_timer <= TIMER_BITS'(1)) begin
                unique case (r_phase)
                    omw_pkg::PH_RST_LOW: begin
                        n_phase = omw_pkg::PH_RST_WAIT;
                        n_drive = 1'b0;
                        n_timer = TIMER_BITS'(i_timing.presence_wait_time);
                    end
                    omw_pkg::PH_RST_WAIT: begin
                        n_pres  = ~i_bus_level;
                        n_phase = omw_pkg::PH_RST_TAIL;
                        n_drive = 1'b0;
                        n_timer = TIMER_BITS'(i_timing.reset_tail_time);
                    end
                    omw_pkg::PH_WR_LOW: begin
                        n_phase = omw_pkg::PH_WR_REL;
                        n_drive = 1'b0;
                        n_timer = r_shift[0] ? TIMER_BITS'(i_timing.slot_long_time)
                                             : TIMER_BITS'(i_timing.slot_short_time);
                    end
                    omw_pkg::PH_WR_REL: begin
                        if (r_bit_idx == omw_pkg::LAST_BIT) begin
                            done = 1'b1;
                        end else begin
                            n_bit_idx = r_bit_idx + 1'b1;
                            n_shift   = {1'b0, r_shift[omw_pkg::BYTE_BITS-1:1]};
                            n_phase   = omw_pkg::PH_WR_LOW;
                            n_drive   = 1'b1;
                            n_timer   = r_shift[1] ? TIMER_BITS'(i_timing.slot_short_time)
                                                   : TIMER_BITS'(i_timing.slot_long_time);
                        end
                    end
                    omw_pkg::PH_RD_LOW: begin
                        n_phase = omw_pkg::PH_RD_WAIT;
                        n_drive = 1'b0;
                        n_timer = TIMER_BITS'(i_timing.read_sample_time);
                    end
                    omw_pkg::PH_RD_WAIT: begin
                        n_shift = {i_bus_level, r_shift[omw_pkg::BYTE_BITS-1:1]};
                        n_phase = omw_pkg::PH_RD_TAIL;
                        n_drive = 1'b0;
                        n_timer = TIMER_BITS'(i_timing.read_tail_time);
                    end
                    omw_pkg::PH_RD_TAIL: begin
                        if (r_bit_idx == omw_pkg::LAST_BIT) begin
                            n_rdata = r_shift;
                            done    = 1'b1;
                        end else begin
                            n_bit_idx = r_bit_idx + 1'b1;
                            n_phase   = omw_pkg::PH_RD_LOW;
                            n_drive   = 1'b1;
                            n_timer   = TIMER_BITS'(i_timing.read_low_time);
                        end
                    end
                    default: begin
                        // reset tail end, or any unused code: finish the sequence
                        done = (r_phase == omw_pkg::PH_RST_TAIL);
                    end
                endcase
                if (done || r_phase == omw_pkg::PH_IDLE || r_phase > omw_pkg::PH_RD_TAIL) begin
                    n_phase = omw_pkg::PH_IDLE;
                    n_drive = 1'b0;
                    n_timer = '0;
                end
            end else begin
                n_timer = r_timer - TIMER_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= omw_pkg::PH_IDLE;
            r_timer   <= '0;
            r_bit_idx <= '0;
            r_shift   <= '0;
            r_drive   <= 1'b0;
            r_pres    <= 1'b0;
            r_rdata   <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_drive   <= n_drive;
            r_pres    <= n_pres;
            r_rdata   <= n_rdata;
        end
    end

    always_comb begin
        o_result.drive_low = n_drive;
        o_result.busy_res  = (n_phase != omw_pkg::PH_IDLE);
        o_result.done_res  = done;
        o_result.presence  = n_pres;
        o_result.read_data = n_rdata;
        o_result.rejected  = rej;
    end

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && rej) |=> ($stable(r_phase) && $stable(r_timer) && $stable(r_shift)))
        else $error("rejected command changed sequencer state");

    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && done) |=> (r_phase == omw_pkg::PH_IDLE && !r_drive))
        else $error("finished sequence left the bus driven or busy");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == omw_pkg::PH_IDLE) |-> !r_drive)
        else $error("bus driven low while idle");

endmodule
`default_nettype wire

/* hdl/omw_ostg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// omw_ostg
// Result register with a skid entry between sequencer and result channel.
// ----------------------------------------------------------------------------
module omw_ostg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire omw_pkg::t_result  i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output omw_pkg::t_result       o_data
);

    logic             r_main_v;
    logic             r_skid_v;
    omw_pkg::t_result r_main;
    omw_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_main_v && i_ready;
    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || pop) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || pop) begin
            r_main <= r_skid_v ? r_skid : i_data;
        end
        if (i_push && r_main_v && !pop) begin
            r_skid <= i_data;
        end
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry holds a result while the main register is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !pop) |=> r_skid_v)
        else $error("skid entry dropped before the result was taken");

endmodule
`default_nettype wire

/* hdl/one_wire_master_timing.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_master_timing
// One-wire bus master sequencer paced by one-microsecond tick transactions.
// ----------------------------------------------------------------------------
// Results: each accepted transaction's result is registered. Throughput: one
// input transaction per cycle while the skid entry is free; the single
// sequencer register stage plus a two-entry result stage sets this figure.
// Reset: synchronous, active low; the sequencer returns to idle with the bus
// released, timing registers load their defaults and the result stage empties.
// ----------------------------------------------------------------------------
module one_wire_master_timing #(
    parameter int TIMER_BITS = omw_pkg::TIMER_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    omw_in_if.sink     i_in,
    omw_out_if.source  o_out,
    omw_cfg_if.sink    i_cfg
);

    omw_pkg::t_timing timing;
    omw_pkg::t_result seq_result;
    omw_pkg::t_result out_result;
    logic             in_ready;
    logic             in_accept;
    logic             out_valid;

    // Timing registers take a write transaction in any cycle; the host must only
    // write them while no sequence runs, which the block itself does not enforce.
    assign i_cfg.ready = 1'b1;

    omw_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_idx  (i_cfg.index),
        .i_wr_data (i_cfg.data),
        .o_timing  (timing)
    );

    // Advance the sequencer only on an accepted transaction; hold otherwise.
    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid && in_ready;

    omw_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_opcode     (i_in.opcode),
        .i_write_byte (i_in.write_byte),
        .i_bus_level  (i_in.bus_level),
        .i_timing     (timing),
        .o_result     (seq_result)
    );

    // Register the result; the skid entry takes one more input transaction
    // while the result channel stalls.
    omw_ostg u_ostg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (seq_result),
        .o_ready (in_ready),
        .o_valid (out_valid),
        .i_ready (o_out.ready),
        .o_data  (out_result)
    );

    assign o_out.valid     = out_valid;
    assign o_out.drive_low = out_result.drive_low;
    assign o_out.busy_res  = out_result.busy_res;
    assign o_out.done_res  = out_result.done_res;
    assign o_out.presence  = out_result.presence;
    assign o_out.read_data = out_result.read_data;
    assign o_out.rejected  = out_result.rejected;

endmodule
`default_nettype wire

/* tb/sv/one_wire_master_timing_tb.sv */
// ----------------------------------------------------------------------------
// one_wire_master_timing_tb
// Self-checking bench for the one-wire bus master sequencer. A table of
// directed transactions runs first at the default and at the shortest
// timings. Random reset, write and read sequences follow at short random
// timings in every pacing mode. Every result transaction is compared
// against an in-bench model of the sequencer or a row's typed result.
// ----------------------------------------------------------------------------
module one_wire_master_timing_tb;
    import omw_pkg::*;

    // Stop the random part once this many transactions have reached a busy
    // sequencer or carried a command, and every pacing mode has run.
    localparam int unsigned RANDOM_ITEMS   = 700;
    localparam int unsigned SETTLE_LIMIT   = 1000;
    localparam int unsigned RESULT_LATENCY = 1;
    localparam int unsigned DIRECTED_ROWS  = 25;

    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } t_pace;

    // One row of the directed table: either a timing update that sets every
    // register to cfg_val, or reps copies of one input transaction. When
    // typed is set, the last copy is checked against want instead of the
    // model.
    typedef struct packed {
        logic                     cfg_row;
        logic [CFG_DATA_BITS-1:0] cfg_val;
        t_opcode                  op;
        logic [BYTE_BITS-1:0]     wb;
        logic                     lvl;
        logic [15:0]              reps;
        logic                     typed;
        t_result                  want;
    } t_stim_row;

    logic clk;
    logic rst_n;

    omw_in_if  in_ch ();
    omw_out_if out_ch ();
    omw_cfg_if cfg_ch ();

    one_wire_master_timing i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Sequencer model state, updated once per accepted input transaction
    // ------------------------------------------------------------------
    t_phase                   seq_phase;
    logic [CFG_DATA_BITS-1:0] slot_timer;
    logic [BIT_IDX_BITS-1:0]  bit_count;
    logic [BYTE_BITS-1:0]     shift_reg;
    logic                     line_low;
    logic                     presence_seen;
    logic [BYTE_BITS-1:0]     last_read;
    logic [CFG_DATA_BITS-1:0] timing [8];

    t_result     pending_bus_results [$];
    t_stim_row   directed_rows [DIRECTED_ROWS];
    int unsigned mismatch_count;
    int unsigned active_items;
    int unsigned send_idle_pct;
    int unsigned stall_pct;

    // ------------------------------------------------------------------
    // Clock, and the hard stop for a hung handshake
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------
    function automatic void enter_phase(t_phase p, logic drv, logic [CFG_DATA_BITS-1:0] ticks);
        seq_phase  = p;
        line_low   = drv;
        slot_timer = ticks;
    endfunction

    // Write slot length for the current LSB: a 1 is short low then long
    // release, a 0 is long low then short release.
    function automatic logic [CFG_DATA_BITS-1:0] slot_ticks(logic releasing);
        return (shift_reg[0] ^ releasing) ? timing[REG_SLOT_SHORT] : timing[REG_SLOT_LONG];
    endfunction

    function automatic t_result outcome(logic drv, logic busy, logic done, logic pres,
                                        logic [BYTE_BITS-1:0] rd, logic rej);
        t_result r;
        r.drive_low = drv;
        r.busy_res  = busy;
        r.done_res  = done;
        r.presence  = pres;
        r.read_data = rd;
        r.rejected  = rej;
        return r;
    endfunction

    // Advance the sequencer model by one transaction and return the result
    // that the block should show for it.
    function automatic t_result predict_bus_step(t_opcode op, logic [BYTE_BITS-1:0] wb,
                                                 logic lvl);
        t_result r;
        logic    was_busy;
        logic    ended;
        was_busy = (seq_phase != PH_IDLE);
        ended    = 1'b0;
        r        = '0;
        if (op != OP_TICK) begin
            if (was_busy) begin
                // Ignore a command while busy; the timer does not move.
                r.rejected = 1'b1;
            end else begin
                bit_count = '0;
                case (op)
                    OP_RESET: enter_phase(PH_RST_LOW, 1'b1, timing[REG_RESET_LOW]);
                    OP_WRITE: begin
                        shift_reg = wb;
                        enter_phase(PH_WR_LOW, 1'b1, slot_ticks(1'b0));
                    end
                    default: begin
                        shift_reg = '0;
                        enter_phase(PH_RD_LOW, 1'b1, timing[REG_READ_LOW]);
                    end
                endcase
            end
        end else if (was_busy && slot_timer > 1) begin
            slot_timer = slot_timer - 1'b1;
        end else if (was_busy) begin
            // Last tick of the phase: sample where due, then move on.
            case (seq_phase)
                PH_RST_LOW:  enter_phase(PH_RST_WAIT, 1'b0, timing[REG_PRESENCE_WAIT]);
                PH_RST_WAIT: begin
                    presence_seen = ~lvl;
                    enter_phase(PH_RST_TAIL, 1'b0, timing[REG_RESET_TAIL]);
                end
                PH_RST_TAIL: ended = 1'b1;
                PH_WR_LOW:   enter_phase(PH_WR_REL, 1'b0, slot_ticks(1'b1));
                PH_WR_REL: begin
                    if (bit_count == LAST_BIT) begin
                        ended = 1'b1;
                    end else begin
                        bit_count = bit_count + 1'b1;
                        shift_reg = shift_reg >> 1;
                        enter_phase(PH_WR_LOW, 1'b1, slot_ticks(1'b0));
                    end
                end
                PH_RD_LOW:   enter_phase(PH_RD_WAIT, 1'b0, timing[REG_READ_SAMPLE]);
                PH_RD_WAIT: begin
                    shift_reg = {lvl, shift_reg[BYTE_BITS-1:1]};
                    enter_phase(PH_RD_TAIL, 1'b0, timing[REG_READ_TAIL]);
                end
                PH_RD_TAIL: begin
                    if (bit_count == LAST_BIT) begin
                        last_read = shift_reg;
                        ended     = 1'b1;
                    end else begin
                        bit_count = bit_count + 1'b1;
                        enter_phase(PH_RD_LOW, 1'b1, timing[REG_READ_LOW]);
                    end
                end
                default: enter_phase(PH_IDLE, 1'b0, '0);
            endcase
        end
        if (ended) begin
            enter_phase(PH_IDLE, 1'b0, '0);
        end
        r.drive_low = line_low;
        r.busy_res  = (seq_phase != PH_IDLE);
        r.done_res  = ended;
        r.presence  = presence_seen;
        r.read_data = last_read;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall on ready, compare every accepted result
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin : result_checker
        t_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_bus_results.size() == 0) begin
                $error("result transaction with no expected result pending");
                mismatch_count++;
            end else begin
                want = pending_bus_results.pop_front();
                check_field("drive_low", 32'(want.drive_low), 32'(out_ch.drive_low));
                check_field("busy_res",  32'(want.busy_res),  32'(out_ch.busy_res));
                check_field("done_res",  32'(want.done_res),  32'(out_ch.done_res));
                check_field("presence",  32'(want.presence),  32'(out_ch.presence));
                check_field("read_data", 32'(want.read_data), 32'(out_ch.read_data));
                check_field("rejected",  32'(want.rejected),  32'(out_ch.rejected));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------
    task automatic set_pace(t_pace pace);
        case (pace)
            PACE_SENDER_IDLE:    begin send_idle_pct = 77; stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin send_idle_pct = 0;  stall_pct = 77; end
            PACE_BOTH:           begin send_idle_pct = 31; stall_pct = 31; end
            default:             begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Offer one input transaction, hold it until accepted, then queue the
    // expected result. Valid stays high into the next call unless that call
    // opens a gap, so it never gets two updates in one step.
    task automatic send_item(t_opcode op, logic [BYTE_BITS-1:0] wb, logic lvl,
                             logic typed, t_result want);
        t_result predicted;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.write_byte <= wb;
        in_ch.bus_level  <= lvl;
        do @(posedge clk); while (!in_ch.ready);
        if (op != OP_TICK || seq_phase != PH_IDLE) begin
            active_items++;
        end
        predicted = predict_bus_step(op, wb, lvl);
        pending_bus_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait for every expected result, with a bound; then
    // hold off while the result stage empties.
    task automatic settle_bus();
        int unsigned waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_bus_results.size() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (pending_bus_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_bus_results.size());
            mismatch_count++;
            pending_bus_results.delete();
        end
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    // Rewrite all eight timing registers, either to one value or to short
    // random values with an occasional longer one.
    task automatic program_timing(logic pick_random, logic [CFG_DATA_BITS-1:0] fixed_val);
        logic [CFG_DATA_BITS-1:0] v;
        settle_bus();
        for (int i = 0; i < 8; i++) begin
            if (!pick_random) begin
                v = fixed_val;
            end else if ($urandom_range(7) == 0) begin
                v = CFG_DATA_BITS'($urandom_range(40, 1));
            end else begin
                v = CFG_DATA_BITS'($urandom_range(4, 1));
            end
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= t_reg_idx'(i);
            cfg_ch.data  <= v;
            do @(posedge clk); while (!cfg_ch.ready);
            timing[i] = v;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Run whole sequences: some idle ticks as noise, one command, then ticks
    // until the sequencer is idle again, with an odd command thrown in while
    // busy to exercise the reject path.
    task automatic run_bus_sequences(int unsigned n, logic rotate_ops);
        t_opcode op;
        for (int unsigned s = 0; s < n; s++) begin
            while ($urandom_range(7) == 0) begin
                send_item(OP_TICK, BYTE_BITS'($urandom_range(255)), 1'($urandom_range(1)),
                          1'b0, '0);
            end
            op = rotate_ops ? t_opcode'(1 + s % 3) : t_opcode'($urandom_range(3, 1));
            send_item(op, BYTE_BITS'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
            while (seq_phase != PH_IDLE) begin
                if ($urandom_range(11) == 0) begin
                    op = t_opcode'($urandom_range(3, 1));
                end else begin
                    op = OP_TICK;
                end
                send_item(op, BYTE_BITS'($urandom_range(255)), 1'($urandom_range(1)),
                          1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase_no;

        // Rows 0-7 run a full reset at the default timings with a presence
        // response; the rest run at the shortest timings: extreme write
        // bytes, rejected commands, reads of all ones and all zeros.
        directed_rows = '{
            '{1'b0, 10'd0, OP_TICK,  8'h3C, 1'b0, 16'd1,   1'b1,
              outcome(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0)},
            '{1'b0, 10'd0, OP_RESET, 8'h00, 1'b1, 16'd1,   1'b1,
              outcome(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0)},
            '{1'b0, 10'd0, OP_WRITE, 8'h5A, 1'b1, 16'd1,   1'b1,
              outcome(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1)},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b1, 16'd500, 1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b1, 16'd69,  1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'hFF, 1'b0, 16'd1,   1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b1, 16'd419, 1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b1, 16'd1,   1'b1,
              outcome(1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0)},
            '{1'b1, 10'd1, OP_TICK,  8'h00, 1'b0, 16'd0,   1'b0, '0},
            '{1'b0, 10'd0, OP_RESET, 8'h00, 1'b1, 16'd1,   1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b1, 16'd3,   1'b0, '0},
            '{1'b0, 10'd0, OP_WRITE, 8'hFF, 1'b1, 16'd1,   1'b0, '0},
            '{1'b0, 10'd0, OP_READ,  8'h00, 1'b0, 16'd1,   1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b0, 16'd16,  1'b0, '0},
            '{1'b0, 10'd0, OP_WRITE, 8'h00, 1'b1, 16'd1,   1'b0, '0},
            '{1'b0, 10'd0, OP_RESET, 8'h00, 1'b0, 16'd1,   1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b1, 16'd16,  1'b0, '0},
            '{1'b0, 10'd0, OP_WRITE, 8'hA5, 1'b1, 16'd1,   1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b0, 16'd16,  1'b0, '0},
            '{1'b0, 10'd0, OP_READ,  8'h00, 1'b1, 16'd1,   1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b1, 16'd23,  1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b1, 16'd1,   1'b1,
              outcome(1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, 1'b0)},
            '{1'b0, 10'd0, OP_READ,  8'hC3, 1'b0, 16'd1,   1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h00, 1'b0, 16'd24,  1'b0, '0},
            '{1'b0, 10'd0, OP_TICK,  8'h81, 1'b1, 16'd1,   1'b0, '0}
        };

        // Drive every input to a known value before the first edge.
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_TICK;
        in_ch.write_byte = '0;
        in_ch.bus_level  = 1'b1;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_RESET_LOW;
        cfg_ch.data      = '0;
        out_ch.ready     = 1'b0;
        mismatch_count   = 0;
        active_items     = 0;
        set_pace(PACE_FULL);

        // Model after reset: idle, line released, default timings.
        seq_phase     = PH_IDLE;
        slot_timer    = '0;
        bit_count     = '0;
        shift_reg     = '0;
        line_low      = 1'b0;
        presence_seen = 1'b0;
        last_read     = '0;
        timing[REG_RESET_LOW]     = RESET_LOW_DEF;
        timing[REG_PRESENCE_WAIT] = PRESENCE_WAIT_DEF;
        timing[REG_RESET_TAIL]    = RESET_TAIL_DEF;
        timing[REG_SLOT_SHORT]    = SLOT_SHORT_DEF;
        timing[REG_SLOT_LONG]     = SLOT_LONG_DEF;
        timing[REG_READ_LOW]      = READ_LOW_DEF;
        timing[REG_READ_SAMPLE]   = READ_SAMPLE_DEF;
        timing[REG_READ_TAIL]     = READ_TAIL_DEF;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg_row) begin
                program_timing(1'b0, directed_rows[i].cfg_val);
            end else begin
                for (int unsigned k = 0; k < directed_rows[i].reps; k++) begin
                    send_item(directed_rows[i].op, directed_rows[i].wb, directed_rows[i].lvl,
                              directed_rows[i].typed && (k == directed_rows[i].reps - 1),
                              directed_rows[i].want);
                end
            end
        end

        // Random part: rotate through the pacing modes, new short timings
        // each phase, until every mode ran and enough transactions reached
        // the sequencer.
        active_items = 0;
        phase_no     = 0;
        while (active_items < RANDOM_ITEMS || phase_no < 4) begin
            set_pace(t_pace'(phase_no % 4));
            program_timing(1'b1, '0);
            run_bus_sequences(2, 1'b0);
            phase_no++;
        end

        settle_bus();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
